// ----- sv/qap2d_pkg.sv -----
// Shared types, widths and constants of the quantized average pool block.
// Used by the top level, the serial divider and the port checker.
// Depends on nothing.
package qap2d_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_DIM     = 64;
  localparam int DEF_PLANE_WORDS = 4096;
  localparam int DEF_MAX_KERNEL  = 15;

  // Datapath widths.
  localparam int SUM_W       = 18;  // signed window sum, up to 225 terms of 10 bits
  localparam int MAG_W       = 17;  // magnitude of the window sum
  localparam int PROD_W      = 41;  // magnitude times the Q8.16 scale
  localparam int QHI_W       = 25;  // product with the 16 fraction bits dropped
  localparam int CNT_W       = 8;   // divisor, 1 to 225
  localparam int VAL_W       = 27;  // signed value before saturation
  localparam int ADDR_CALC_W = 17;  // plane address before range check

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_IN_HEIGHT    = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH     = 3'd1;
  localparam logic [2:0] REG_WINDOW_SHAPE = 3'd2;
  localparam logic [2:0] REG_WINDOW_STEPS = 3'd3;
  localparam logic [2:0] REG_INPUT_ZERO   = 3'd4;
  localparam logic [2:0] REG_OUTPUT_ZERO  = 3'd5;
  localparam logic [2:0] REG_SCALE_RATIO  = 3'd6;
  localparam logic [2:0] REG_MODE         = 3'd7;

  // Command codes of an input word.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_POOL  = 1'b1;

  // Saturation bounds of the pooled value.
  localparam logic signed [8:0] POOL_S_MIN = -9'sd128;
  localparam logic signed [8:0] POOL_S_MAX = 9'sd127;
  localparam logic signed [8:0] POOL_U_MIN = 9'sd0;
  localparam logic signed [8:0] POOL_U_MAX = 9'sd255;

  // Request to and response from the serial divider.
  typedef struct packed {
    logic             start;
    logic [QHI_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QHI_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

  // Sign-extend a 9-bit value to the saturation width.
  function automatic logic signed [VAL_W-1:0] widen9(input logic signed [8:0] v);
    return {{(VAL_W-9){v[8]}}, v};
  endfunction

endpackage

// ----- sv/qap2d_plane.sv -----
// Plane memory of the average pool: one write port, one registered read port.
// Depends on nothing.
module qap2d_plane #(
  parameter int WORDS = 4096
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
  input  logic [7:0]                            wr_data,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
  output logic [7:0]                            rd_data
);

  logic [7:0] mem [WORDS];

  // Write side.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read side.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/qap2d_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on qap2d_pkg for the request and response structs.
module qap2d_div
  import qap2d_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(QHI_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [QHI_W-1:0]  work;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, work[QHI_W-1]};
    fits  = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  // Iteration: the quotient bits shift into the dividend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Done is raised for one cycle after the last quotient bit.
      done <= !req.start && busy && (step == STEP_W'(QHI_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        work <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        work <= {work[QHI_W-2:0], fits};
        if (step == STEP_W'(QHI_W - 1)) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = work;
  assign rsp.rem  = rem;

endmodule

// ----- sv/quantized_average_pool_2d.sv -----
// Top level of the quantized 2-D average pool: configuration, window sequencer,
// accumulator, scale multiply, rounding and saturation.
// Depends on qap2d_pkg, qap2d_plane and qap2d_div.
//
// Usage. The input channel (in_valid / in_stall) carries two kinds of word.
// A store word writes pixel_value[7:0] at pixel_addr of the plane memory;
// it gives no result. A pool word walks the kernel window at (out_row,
// out_col), one plane read per cycle, then drains the last read, multiplies
// the sum by scale_ratio and divides by the count in a serial divider.
// in_stall is high from acceptance until the result is in the output
// register. The result waits in the output register (out_valid /
// out_stall) and the next word is accepted while it waits; a following
// pool word holds in its last step until the register is free.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block itself does not
// enforce. Reset clears the sequencer, the output valid and the registers to
// their defaults; the plane contents are undefined until stored.
module quantized_average_pool_2d
  import qap2d_pkg::*;
#(
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int PLANE_WORDS = DEF_PLANE_WORDS,
  parameter int MAX_KERNEL  = DEF_MAX_KERNEL
) (
  input  logic              clk,
  input  logic              rst,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [11:0]       pixel_addr,
  input  logic signed [8:0] pixel_value,
  input  logic [6:0]        out_row,
  input  logic [6:0]        out_col,
  // Output channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [8:0] pooled_value,
  output logic [7:0]        window_count,
  output logic              clipped,
  // Configuration port.
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int ADDR_W  = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;
  localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
  localparam logic [ADDR_CALC_W-1:0] WORDS_LIM = ADDR_CALC_W'(PLANE_WORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  // Configuration registers.
  logic [6:0]        in_height;
  logic [6:0]        in_width;
  logic [7:0]        window_shape;
  logic [15:0]       window_steps;
  logic signed [8:0] input_zero;
  logic signed [8:0] output_zero;
  logic [23:0]       scale_ratio;
  logic [1:0]        mode;

  // Sequencer and datapath registers.
  state_t                   state;
  logic signed [11:0]       row_pos;
  logic signed [11:0]       col_pos;
  logic signed [11:0]       col_start;
  logic [3:0]               r_idx;
  logic [3:0]               c_idx;
  logic                     acc_valid;
  logic                     zero_d;
  logic signed [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]         count;
  logic                     sum_neg;
  logic [PROD_W-1:0]        product;
  logic [QHI_W:0]           q_round;

  // Derived configuration.
  logic [6:0] hgt, wid;
  logic [3:0] kh, kw, sh, sw, pt, pl;
  logic       sgn, incl;

  // Combinational signals.
  logic                     accept;
  logic                     st_en;
  logic [ADDR_CALC_W-1:0]   st_addr;
  logic [10:0]              row_scaled, col_scaled;
  logic signed [11:0]       row_start, col_first;
  logic                     row_ok, col_ok, in_bounds;
  logic [13:0]              row_base;
  logic [ADDR_CALC_W-1:0]   rd_addr;
  logic                     addr_ok;
  logic [7:0]               rd_data;
  logic signed [8:0]        px;
  logic signed [9:0]        term;
  logic signed [SUM_W-1:0]  sum_negd;
  logic [MAG_W-1:0]         sum_mag;
  logic [QHI_W-1:0]         twice_rem;
  logic [QHI_W-1:0]         den_half;
  logic                     round_up;
  logic signed [VAL_W-1:0]  q_signed;
  logic signed [VAL_W-1:0]  val_raw;
  logic signed [VAL_W-1:0]  sat_lo, sat_hi;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Field extraction and clamping of the configuration.
  always_comb begin
    hgt  = (in_height > 7'(DIM_CAP)) ? 7'(DIM_CAP) : in_height;
    wid  = (in_width > 7'(DIM_CAP)) ? 7'(DIM_CAP) : in_width;
    kh   = (window_shape[3:0] > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : window_shape[3:0];
    kw   = (window_shape[7:4] > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : window_shape[7:4];
    sh   = window_steps[3:0];
    sw   = window_steps[7:4];
    pt   = window_steps[11:8];
    pl   = window_steps[15:12];
    sgn  = mode[0];
    incl = mode[1];
  end

  // Input handshake and store path.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign st_addr  = {{(ADDR_CALC_W-12){1'b0}}, pixel_addr};
  assign st_en    = accept && (command == CMD_STORE) && (st_addr < WORDS_LIM);

  // Window origin of a pool word.
  always_comb begin
    row_scaled = out_row * sh;
    col_scaled = out_col * sw;
    row_start  = $signed({1'b0, row_scaled}) - $signed({8'b0, pt});
    col_first  = $signed({1'b0, col_scaled}) - $signed({8'b0, pl});
  end

  // Bounds check and plane address of the current window position.
  always_comb begin
    row_ok    = !row_pos[11] && (row_pos < $signed({5'b0, hgt}));
    col_ok    = !col_pos[11] && (col_pos < $signed({5'b0, wid}));
    in_bounds = row_ok && col_ok;
    row_base  = row_pos[6:0] * wid;
    rd_addr   = {{(ADDR_CALC_W-14){1'b0}}, row_base}
              + {{(ADDR_CALC_W-7){1'b0}}, col_pos[6:0]};
    addr_ok   = (rd_addr < WORDS_LIM);
  end

  qap2d_plane #(
    .WORDS (PLANE_WORDS)
  ) u_plane (
    .clk     (clk),
    .wr_en   (st_en),
    .wr_addr (st_addr[ADDR_W-1:0]),
    .wr_data (pixel_value[7:0]),
    .rd_addr (rd_addr[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Term added to the sum in the cycle after its read.
  always_comb begin
    if (zero_d) begin
      px = '0;
    end else if (sgn) begin
      px = {rd_data[7], rd_data};
    end else begin
      px = {1'b0, rd_data};
    end
    term = {px[8], px} - {input_zero[8], input_zero};
  end

  // Magnitude of the sum for the unsigned scale multiply.
  always_comb begin
    sum_negd = -sum;
    sum_mag  = sum[SUM_W-1] ? sum_negd[MAG_W-1:0] : sum[MAG_W-1:0];
  end

  // Divider request: the 16 fraction bits of the product are kept aside.
  assign div_req.start    = (state == S_DIV_START);
  assign div_req.dividend = product[PROD_W-1:16];
  assign div_req.divisor  = count;

  qap2d_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Round half to even: compare twice the full remainder with the divisor.
  always_comb begin
    twice_rem = {div_rsp.rem, product[15:0], 1'b0};
    den_half  = {1'b0, count, 16'b0};
    round_up  = (twice_rem > den_half) || ((twice_rem == den_half) && div_rsp.quot[0]);
  end

  // Sign, output zero point and saturation.
  always_comb begin
    q_signed = $signed({1'b0, q_round});
    val_raw  = (sum_neg ? -q_signed : q_signed) + widen9(output_zero);
    sat_lo   = sgn ? widen9(POOL_S_MIN) : widen9(POOL_U_MIN);
    sat_hi   = sgn ? widen9(POOL_S_MAX) : widen9(POOL_U_MAX);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_height    <= 7'd1;
      in_width     <= 7'd1;
      window_shape <= 8'd17;
      window_steps <= 16'd17;
      input_zero   <= '0;
      output_zero  <= '0;
      scale_ratio  <= 24'd65536;
      mode         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_HEIGHT:    in_height    <= cfg_data[6:0];
        REG_IN_WIDTH:     in_width     <= cfg_data[6:0];
        REG_WINDOW_SHAPE: window_shape <= cfg_data[7:0];
        REG_WINDOW_STEPS: window_steps <= cfg_data[15:0];
        REG_INPUT_ZERO:   input_zero   <= $signed(cfg_data[8:0]);
        REG_OUTPUT_ZERO:  output_zero  <= $signed(cfg_data[8:0]);
        REG_SCALE_RATIO:  scale_ratio  <= cfg_data[23:0];
        REG_MODE:         mode         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A read issued while walking is registered in the plane and in acc_valid, then added to the sum.
      acc_valid <= (state == S_WALK) && in_bounds;
      zero_d    <= !addr_ok;
      if (acc_valid) begin
        sum <= sum + {{(SUM_W-10){term[9]}}, term};
      end

      // A taken result empties the register unless a new one replaces it.
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && (command == CMD_POOL)) begin
            row_pos   <= row_start;
            col_pos   <= col_first;
            col_start <= col_first;
            r_idx     <= '0;
            c_idx     <= '0;
            sum       <= '0;
            count     <= '0;
            if ((kh == 4'd0) || (kw == 4'd0)) begin
              state <= S_MUL;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (in_bounds || incl) begin
            count <= count + 1'b1;
          end
          if (c_idx == kw - 4'd1) begin
            c_idx   <= '0;
            col_pos <= col_start;
            row_pos <= row_pos + 12'sd1;
            if (r_idx == kh - 4'd1) begin
              state <= S_DRAIN;
            end else begin
              r_idx <= r_idx + 1'b1;
            end
          end else begin
            c_idx   <= c_idx + 1'b1;
            col_pos <= col_pos + 12'sd1;
          end
        end
        S_DRAIN: begin
          state <= S_MUL;
        end
        S_MUL: begin
          sum_neg <= sum[SUM_W-1];
          product <= sum_mag * scale_ratio;
          if (count == '0) begin
            count <= CNT_W'(1);
          end
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            q_round <= {1'b0, div_rsp.quot} + (QHI_W+1)'(round_up);
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            window_count <= count;
            if (val_raw < sat_lo) begin
              pooled_value <= sat_lo[8:0];
              clipped      <= 1'b1;
            end else if (val_raw > sat_hi) begin
              pooled_value <= sat_hi[8:0];
              clipped      <= 1'b1;
            end else begin
              pooled_value <= val_raw[8:0];
              clipped      <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/qap2d_checker.sv -----
// Port checker of the quantized average pool, bound to the top level.
// Depends on qap2d_pkg and on the port names of quantized_average_pool_2d.
module qap2d_checker
  import qap2d_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              command,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [8:0] pooled_value,
  input logic [7:0]        window_count,
  input logic              clipped
);

  // A stalled result word stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pooled_value)
      && $stable(window_count) && $stable(clipped))
    else $error("result word changed while stalled");

  // A store word never produces a result.
  a_store_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_STORE) && !out_valid |=> !out_valid)
    else $error("result appeared after a store word");

  // A pool word keeps the input side busy on the next cycle.
  a_pool_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_POOL) |=> in_stall)
    else $error("input accepted right after a pool word");

  // The divisor shown is never zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_count != 8'd0))
    else $error("window count of zero");

  // A saturated result sits on one of the range bounds.
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (pooled_value == POOL_S_MIN) || (pooled_value == POOL_S_MAX)
      || (pooled_value == POOL_U_MIN) || (pooled_value == POOL_U_MAX))
    else $error("clipped result not at a bound");

endmodule

bind quantized_average_pool_2d qap2d_checker u_checker (.*);

// ----- tb/quantized_average_pool_2d_tb.sv -----
// Self-checking testbench of the quantized 2-D average pool: directed and random
// store and pool words, with a predictor that recomputes every pooled result.
// Depends on qap2d_pkg and quantized_average_pool_2d.
module quantized_average_pool_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qap2d_pkg::*;

  localparam int MAX_DIM       = DEF_MAX_DIM;
  localparam int PLANE_WORDS   = DEF_PLANE_WORDS;
  localparam int MAX_KERNEL    = DEF_MAX_KERNEL;
  localparam int MODE_SIGNED   = 0;
  localparam int MODE_PAD      = 1;
  localparam int SETTLE_CYCLES = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_WORDS  = 1200;
  localparam int PHASE_WORDS   = 100;

  typedef struct packed {
    logic              cmd;
    logic [11:0]       addr;
    logic signed [8:0] value;
    logic [6:0]        row;
    logic [6:0]        col;
  } plane_word_t;

  typedef struct packed {
    logic signed [8:0] value;
    logic [7:0]        count;
    logic              clip;
  } pool_result_t;

  typedef struct {
    int hgt;
    int wid;
    int kh;
    int kw;
    int row0;
    int col0;
  } window_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_STORE;
  logic [11:0]       pixel_addr = '0;
  logic signed [8:0] pixel_value = '0;
  logic [6:0]        out_row = '0;
  logic [6:0]        out_col = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [8:0] pooled_value;
  logic [7:0]        window_count;
  logic              clipped;
  logic              cfg_write = 1'b0;
  logic [2:0]        cfg_index = REG_IN_HEIGHT;
  logic [23:0]       cfg_data = '0;

  // Register copies, starting from the reset values.
  logic [6:0]        cfg_height = 7'd1;
  logic [6:0]        cfg_width = 7'd1;
  logic [7:0]        cfg_shape = 8'h11;
  logic [15:0]       cfg_steps = 16'h0011;
  logic signed [8:0] cfg_in_zero = '0;
  logic signed [8:0] cfg_out_zero = '0;
  logic [23:0]       cfg_scale = 24'd65536;
  logic [1:0]        cfg_mode = '0;

  logic [7:0]   plane_copy [PLANE_WORDS];
  bit           written [PLANE_WORDS];
  plane_word_t  pending_words [$];
  pool_result_t pooled_due [$];
  plane_word_t  next_word;
  pool_result_t due_result;
  int           errors = 0;
  int           words_queued = 0;
  bit           steady = 1'b0;

  quantized_average_pool_2d uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A side takes a break with a chance of 7 in 100, except in the steady phase.
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 7);
  endfunction

  // Window placement and clamped sizes for one output position.
  function automatic window_t window_at(input logic [6:0] orow, input logic [6:0] ocol);
    window_t w;
    w.hgt  = (cfg_height > MAX_DIM) ? MAX_DIM : int'(cfg_height);
    w.wid  = (cfg_width > MAX_DIM) ? MAX_DIM : int'(cfg_width);
    w.kh   = (cfg_shape[3:0] > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_shape[3:0]);
    w.kw   = (cfg_shape[7:4] > MAX_KERNEL) ? MAX_KERNEL : int'(cfg_shape[7:4]);
    w.row0 = int'(orow) * int'(cfg_steps[3:0]) - int'(cfg_steps[11:8]);
    w.col0 = int'(ocol) * int'(cfg_steps[7:4]) - int'(cfg_steps[15:12]);
    return w;
  endfunction

  // Expected result of one pool word under the current registers.
  function automatic pool_result_t pool_window(input logic [6:0] orow, input logic [6:0] ocol);
    window_t      w;
    int           ih, iw, addr, px, izp, sum, count;
    longint       num, mag, den, q, rem, val, lo, hi;
    pool_result_t res;
    w = window_at(orow, ocol);
    izp = cfg_in_zero;
    sum = 0;
    count = 0;
    for (int r = 0; r < w.kh; r++) begin
      for (int c = 0; c < w.kw; c++) begin
        ih = w.row0 + r;
        iw = w.col0 + c;
        if (ih < 0 || ih >= w.hgt || iw < 0 || iw >= w.wid) begin
          if (cfg_mode[MODE_PAD]) count++;
        end else begin
          addr = ih * w.wid + iw;
          px = 0;
          if (addr < PLANE_WORDS) begin
            if (cfg_mode[MODE_SIGNED]) px = $signed(plane_copy[addr]);
            else px = plane_copy[addr];
          end
          sum += px - izp;
          count++;
        end
      end
    end
    // An empty count divides by one.
    if (count == 0) count = 1;

    // Scale, then divide by the count with ties going to the even quotient.
    num = longint'(sum) * longint'(cfg_scale);
    mag = (num < 0) ? -num : num;
    den = longint'(count) << 16;
    q = mag / den;
    rem = mag % den;
    if (2 * rem > den || (2 * rem == den && q[0])) q++;
    val = (num < 0) ? -q : q;
    val += cfg_out_zero;

    lo = cfg_mode[MODE_SIGNED] ? POOL_S_MIN : POOL_U_MIN;
    hi = cfg_mode[MODE_SIGNED] ? POOL_S_MAX : POOL_U_MAX;
    res.clip = 1'b0;
    if (val < lo) begin
      val = lo;
      res.clip = 1'b1;
    end
    if (val > hi) begin
      val = hi;
      res.clip = 1'b1;
    end
    res.value = val[8:0];
    res.count = count[7:0];
    return res;
  endfunction

  task automatic push_store(input logic [11:0] addr, input logic [8:0] value);
    plane_word_t word;
    word.cmd   = CMD_STORE;
    word.addr  = addr;
    word.value = value;
    word.row   = 7'($urandom_range(127));
    word.col   = 7'($urandom_range(127));
    pending_words.push_back(word);
    written[addr] = 1'b1;
    words_queued++;
  endtask

  // A pool word is preceded by stores to every pixel of its window not yet written.
  task automatic push_pool(input logic [6:0] orow, input logic [6:0] ocol);
    window_t     w;
    int          ih, iw, addr;
    plane_word_t word;
    w = window_at(orow, ocol);
    for (int r = 0; r < w.kh; r++) begin
      for (int c = 0; c < w.kw; c++) begin
        ih = w.row0 + r;
        iw = w.col0 + c;
        if (ih >= 0 && ih < w.hgt && iw >= 0 && iw < w.wid) begin
          addr = ih * w.wid + iw;
          if (addr < PLANE_WORDS && !written[addr])
            push_store(12'(addr), 9'($urandom_range(511)));
        end
      end
    end
    word.cmd   = CMD_POOL;
    word.addr  = 12'($urandom_range(4095));
    word.value = 9'($urandom_range(511));
    word.row   = orow;
    word.col   = ocol;
    pending_words.push_back(word);
    words_queued++;
  endtask

  // Wait until every word is taken and every result is back, then let the block settle.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || pooled_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_IN_HEIGHT:    cfg_height = data[6:0];
      REG_IN_WIDTH:     cfg_width = data[6:0];
      REG_WINDOW_SHAPE: cfg_shape = data[7:0];
      REG_WINDOW_STEPS: cfg_steps = data[15:0];
      REG_INPUT_ZERO:   cfg_in_zero = data[8:0];
      REG_OUTPUT_ZERO:  cfg_out_zero = data[8:0];
      REG_SCALE_RATIO:  cfg_scale = data;
      REG_MODE:         cfg_mode = data[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [6:0] h, input logic [6:0] w, input logic [7:0] shape,
                           input logic [15:0] steps, input logic [8:0] izp,
                           input logic [8:0] ozp, input logic [23:0] scale,
                           input logic [1:0] mode);
    wait_idle();
    set_reg(REG_IN_HEIGHT, 24'(h));
    set_reg(REG_IN_WIDTH, 24'(w));
    set_reg(REG_WINDOW_SHAPE, 24'(shape));
    set_reg(REG_WINDOW_STEPS, 24'(steps));
    set_reg(REG_INPUT_ZERO, 24'(izp));
    set_reg(REG_OUTPUT_ZERO, 24'(ozp));
    set_reg(REG_SCALE_RATIO, scale);
    set_reg(REG_MODE, 24'(mode));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Plane sizes are mostly small, sometimes past the clamp, sometimes anything.
  function automatic logic [6:0] pick_dim();
    case ($urandom_range(9))
      0:       return 7'($urandom_range(127));
      1:       return 7'($urandom_range(127, 64));
      default: return 7'($urandom_range(16, 1));
    endcase
  endfunction

  function automatic logic [3:0] pick_nibble(input int lo, input int hi);
    if ($urandom_range(99) < 85) return 4'($urandom_range(hi, lo));
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [8:0] pick_zero();
    if ($urandom_range(1) == 0) return 9'($urandom_range(511));
    return 9'(int'($urandom_range(40)) - 20);
  endfunction

  // Most output positions place the window over the plane.
  function automatic logic [6:0] pick_coord(input int dim, input int stride, input int pad);
    int top;
    if (stride == 0 || dim == 0 || $urandom_range(99) < 15) return 7'($urandom_range(127));
    top = (dim - 1 + pad) / stride;
    if (top > 127) top = 127;
    return 7'($urandom_range(top));
  endfunction

  // Input driver: predicts each accepted word and offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (command == CMD_STORE) plane_copy[pixel_addr] = pixel_value[7:0];
        else pooled_due.push_back(pool_window(out_row, out_col));
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && !take_break()) begin
          next_word = pending_words.pop_front();
          in_valid    <= 1'b1;
          command     <= next_word.cmd;
          pixel_addr  <= next_word.addr;
          pixel_value <= next_word.value;
          out_row     <= next_word.row;
          out_col     <= next_word.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic signed [9:0] want,
                             input logic signed [9:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Output monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pooled_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                   $time, pooled_value, window_count);
        end else begin
          due_result = pooled_due.pop_front();
          check_field("pooled_value", due_result.value, pooled_value);
          check_field("window_count", due_result.count, window_count);
          check_field("clipped", due_result.clip, clipped);
        end
      end
      out_stall <= take_break();
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    window_t geo;
    int      phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: a full-scale pixel, then a window entirely off the plane.
    push_store(12'd0, 9'h0FF);
    push_pool(7'd0, 7'd0);
    push_pool(7'd127, 7'd127);

    // Oversized plane, largest kernel, deep padding, extreme zero points and scale.
    configure(7'd127, 7'd127, 8'hFF, 16'h7711, 9'h180, 9'h0FF, 24'hFFFFFF, 2'd3);
    push_store(12'd0, 9'h180);
    push_store(12'd1, 9'h0FF);
    push_pool(7'd0, 7'd0);
    push_pool(7'd63, 7'd63);
    push_pool(7'd127, 7'd0);

    // Empty kernel with zero stride: the count falls back to one.
    configure(7'd8, 7'd8, 8'h00, 16'h2200, 9'h100, 9'h0FF, 24'd0, 2'd2);
    push_pool(7'd5, 7'd9);

    // Zero stride pins the window near the origin; a low offset clips to zero.
    configure(7'd8, 7'd8, 8'h33, 16'h1100, 9'h000, 9'h100, 24'd65536, 2'd0);
    push_pool(7'd100, 7'd100);
    push_pool(7'd0, 7'd0);

    // Rounding ties on a two-pixel window, both signs.
    configure(7'd1, 7'd2, 8'h21, 16'h0011, 9'h000, 9'h000, 24'd65536, 2'd1);
    push_store(12'd0, 9'd1);
    push_store(12'd1, 9'd2);
    push_pool(7'd0, 7'd0);
    push_store(12'd1, 9'd4);
    push_pool(7'd0, 7'd0);
    push_store(12'd0, 9'h1FF);
    push_store(12'd1, 9'h1FE);
    push_pool(7'd0, 7'd0);

    // Random phases, each with its own register setting.
    words_queued = 0;
    phase = 0;
    while (words_queued < RANDOM_WORDS) begin
      configure(pick_dim(), pick_dim(), {pick_nibble(1, 4), pick_nibble(1, 4)},
                {pick_nibble(0, 2), pick_nibble(0, 2), pick_nibble(1, 3), pick_nibble(1, 3)},
                pick_zero(), pick_zero(),
                ($urandom_range(99) < 70) ? 24'($urandom_range(1 << 18))
                                          : 24'($urandom_range(24'hFFFFFF)),
                2'($urandom_range(3)));
      steady = (phase == 3);
      geo = window_at(7'd0, 7'd0);
      repeat (PHASE_WORDS) begin
        if ($urandom_range(99) < 60) begin
          push_pool(pick_coord(geo.hgt, cfg_steps[3:0], cfg_steps[11:8]),
                    pick_coord(geo.wid, cfg_steps[7:4], cfg_steps[15:12]));
        end else if (geo.hgt * geo.wid > 0 && $urandom_range(99) < 80) begin
          push_store(12'($urandom_range(geo.hgt * geo.wid - 1)), 9'($urandom_range(511)));
        end else begin
          push_store(12'($urandom_range(4095)), 9'($urandom_range(511)));
        end
      end
      phase++;
    end
    steady = 1'b0;

    wait_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
